### sv/ilid_pkg.sv
// Package for the indexed insert/delete list.
// Holds the operation and status codes and the cell command struct.
// No dependencies.
`default_nettype none

package ilid_pkg;

    typedef enum logic [2:0] {
        MODE_GET      = 3'd0,
        MODE_INS_HEAD = 3'd1,
        MODE_INS_TAIL = 3'd2,
        MODE_INS_AT   = 3'd3,
        MODE_DEL_AT   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell, at most one bit set.
    typedef struct packed {
        logic get;
        logic ins;
        logic del;
    } cell_cmd_t;

    localparam int VAL_W = 32;

endpackage

`default_nettype wire

### sv/ilid_cell.sv
// One storage cell of the list chain: holds a single entry.
// Shifts from its neighbors, loads a new value or holds. Uses ilid_pkg.
`default_nettype none

module ilid_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  wire logic                        clk,
    input  wire ilid_pkg::cell_cmd_t         cmd,
    input  wire logic [IDX_W-1:0]            idx,
    input  wire logic [ilid_pkg::VAL_W-1:0]  new_val,
    input  wire logic [ilid_pkg::VAL_W-1:0]  left_val,
    input  wire logic [ilid_pkg::VAL_W-1:0]  right_val,
    output logic      [ilid_pkg::VAL_W-1:0]  val,
    output logic      [ilid_pkg::VAL_W-1:0]  rd_val
);
    import ilid_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic             at_idx;
    logic             past_idx;

    assign at_idx   = (idx == MY_IDX);
    assign past_idx = (idx < MY_IDX);

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins && past_idx)
        begin
            val_next = left_val;
        end
        else if (cmd.ins && at_idx)
        begin
            val_next = new_val;
        end
        else if (cmd.del && (past_idx || at_idx))
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val    = val_reg;
    assign rd_val = (cmd.get && at_idx) ? val_reg : '0;

endmodule

`default_nettype wire

### sv/ilid_ctrl.sv
// Operation decode and entry count for the list.
// Checks range and fullness, issues the cell command. Uses ilid_pkg.
`default_nettype none

module ilid_ctrl #(
    parameter int CAPACITY = 64,
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic [2:0]           mode,
    input  wire logic signed [15:0]   position,
    output ilid_pkg::cell_cmd_t       cmd,
    output logic      [IDX_W-1:0]     idx,
    output ilid_pkg::status_t         status,
    output logic                      rd_fail,
    output logic      [CNT_W-1:0]     count_next,
    output logic      [CNT_W-1:0]     count_q
);
    import ilid_pkg::*;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [15:0]      pos_mag;
    logic [15:0]      cnt16;
    logic             pos_neg;
    logic             rd_ok;
    logic             ins_ok;
    logic             full;
    cell_cmd_t        cmd_raw;

    assign pos_neg = position[15];
    assign pos_mag = {1'b0, position[14:0]};
    assign cnt16   = 16'(count_reg);
    assign rd_ok   = !pos_neg && (pos_mag < cnt16);
    assign ins_ok  = pos_neg || (pos_mag <= cnt16);
    assign full    = (count_reg == CNT_FULL);

    always_comb
    begin
        cmd_raw = '0;
        idx     = position[IDX_W-1:0];
        status  = ST_DONE;
        rd_fail = 1'b0;
        case (mode_t'(mode))
            MODE_GET:
            begin
                if (rd_ok)
                begin
                    cmd_raw.get = 1'b1;
                end
                else
                begin
                    status  = ST_RANGE;
                    rd_fail = 1'b1;
                end
            end
            MODE_INS_HEAD:
            begin
                idx = '0;
                if (full)
                    status = ST_FULL;
                else
                    cmd_raw.ins = 1'b1;
            end
            MODE_INS_TAIL:
            begin
                idx = count_reg[IDX_W-1:0];
                if (full)
                    status = ST_FULL;
                else
                    cmd_raw.ins = 1'b1;
            end
            MODE_INS_AT:
            begin
                if (pos_neg)
                    idx = '0;
                if (!ins_ok)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                    cmd_raw.ins = 1'b1;
            end
            MODE_DEL_AT:
            begin
                if (rd_ok)
                    cmd_raw.del = 1'b1;
                else
                    status = ST_RANGE;
            end
            default:
            begin
                status = ST_RANGE;
            end
        endcase
    end

    assign cmd = fire ? cmd_raw : '0;

    always_comb
    begin
        count_next = count_reg;
        if (cmd_raw.ins)
            count_next = count_reg + 1'b1;
        else if (cmd_raw.del)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (fire)
            count_reg <= count_next;
    end

    assign count_q = count_reg;

endmodule

`default_nettype wire

### sv/indexed_list_insert_delete.sv
// Indexed insert/delete list: top level with the cell chain and result register.
// Depends on ilid_pkg, ilid_ctrl and ilid_cell.
//
// An ordered list of up to CAPACITY signed 32-bit entries plus a count.
// Each item transfer carries a mode (get, insert at head, insert at tail,
// insert at index, delete at index), a position and a value, and produces
// exactly one result transfer with read_value, status and entry_count.
// Entries live in a row of CAPACITY cells; every cell compares its own
// position with the item's position and shifts from its left neighbor
// (insert), from its right neighbor (delete), loads the new value or holds.
// A get selects the matching cell's entry. One item completes per clock:
// the result register is loaded at the edge that takes the item, and a
// new item is taken whenever the result register is empty or its result
// is taken in the same cycle. Throughput is thus one item per cycle.
// Status 1 flags an out of range position or an unused mode, status 2 an
// insert into a full list; neither changes the list. entry_count reports
// the low 7 bits of the count after the item.
`default_nettype none

module indexed_list_insert_delete #(
    parameter int CAPACITY = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // item channel
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic [2:0]          mode,
    input  wire logic signed [15:0]  position,
    input  wire logic signed [31:0]  item_value,
    // result channel
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic signed [31:0]       read_value,
    output logic        [1:0]        status,
    output logic        [6:0]        entry_count
);
    import ilid_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             fire;
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] idx;
    status_t          st;
    logic             rd_fail;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_q;
    logic [31:0]      count_ext;

    logic [VAL_W-1:0] cell_val [CAPACITY];
    logic [VAL_W-1:0] cell_rd  [CAPACITY];
    logic [VAL_W-1:0] get_val;

    logic             out_valid_reg;
    logic [VAL_W-1:0] read_value_reg;
    status_t          status_reg;
    logic [6:0]       entry_count_reg;

    // Result register parts the two sides; take a new item if it is free
    // or being drained this cycle.
    assign item_stall = out_valid_reg && result_stall;
    assign fire       = item_valid && !item_stall;

    ilid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .mode       (mode),
        .position   (position),
        .cmd        (cmd),
        .idx        (idx),
        .status     (st),
        .rd_fail    (rd_fail),
        .count_next (count_next),
        .count_q    (count_q)
    );

    // Cell chain. Cell 0 has no left neighbor (never shifted into on
    // insert); the last cell has no right neighbor and holds on delete.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_v;
        logic [VAL_W-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = item_value;
        end
        else
        begin : g_mid_l
            assign left_v = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = cell_val[i];
        end
        else
        begin : g_mid_r
            assign right_v = cell_val[i+1];
        end

        ilid_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .idx       (idx),
            .new_val   (item_value),
            .left_val  (left_v),
            .right_val (right_v),
            .val       (cell_val[i]),
            .rd_val    (cell_rd[i])
        );
    end

    // Only the addressed cell drives a nonzero read value on a get.
    always_comb
    begin
        get_val = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            get_val = get_val | cell_rd[k];
        end
    end

    assign count_ext = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_value_reg  <= rd_fail ? '1 : get_val;
            status_reg      <= st;
            entry_count_reg <= count_ext[6:0];
        end
    end

    assign result_valid = out_valid_reg;
    assign read_value   = read_value_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;

`ifndef SYNTHESIS
    // Every taken item leaves a result behind.
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid)
        else $error("item taken without a result");

    // An accepted insert grows the list by exactly one.
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
        else $error("insert did not grow the count");

    // A full status is only reported while the list is at capacity.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status_reg == ST_FULL) |-> count_q == CNT_W'(CAPACITY))
        else $error("full status with free space");
`endif

endmodule

`default_nettype wire
